### rtl/ptrt_pkg.sv
// Package: widths, constants and rounding helpers for the pose transform unit.
package ptrt_pkg;

   localparam int ROT_FRAC_BITS = 14;
   localparam int RW = ROT_FRAC_BITS + 3;
   localparam int CORDIC_STEPS = 30;
   localparam int CW = 34;
   localparam int ZW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic signed [15:0] HALF_PI = 16'sd12868;
   localparam logic signed [16:0] PI_Q13 = 17'sd25736;

   typedef logic signed [RW-1:0] rot_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic neg;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;  5'd2: v = 32'h0FADBAFC;
         5'd3: v = 32'h07F56EA6;  5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
         5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;  5'd8: v = 32'h003FFFEA;
         5'd9: v = 32'h001FFFFD;  5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF; 5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF; 5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF; 5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF; 5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F; 5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008; 5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
         default: v = 32'h0;
      endcase
      return $signed({2'b00, v});
   endfunction

   // product of two working values, rounded half up back to working precision
   function automatic rot_type mulf(input rot_type a, input rot_type b);
      logic signed [2*RW-1:0] p;
      p = a * b + (2*RW)'(signed'(1) <<< (ROT_FRAC_BITS - 1));
      return RW'(p >>> ROT_FRAC_BITS);
   endfunction

   function automatic rot_type clamp_one(input logic signed [RW:0] v);
      logic signed [RW:0] one;
      one = (RW+1)'(1) <<< ROT_FRAC_BITS;
      if (v > one) return RW'(one);
      if (v < -one) return RW'(-one);
      return RW'(v);
   endfunction

   function automatic logic signed [15:0] to_q14(input rot_type r);
      logic signed [RW+14:0] v;
      if (ROT_FRAC_BITS >= 14) begin
         v = ((RW+15)'(r) + (ROT_FRAC_BITS > 14 ?
              ((RW+15)'(1) <<< (ROT_FRAC_BITS - 15)) : (RW+15)'(0)))
             >>> (ROT_FRAC_BITS - 14);
      end else begin
         v = (RW+15)'(r) <<< (14 - ROT_FRAC_BITS);
      end
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return 16'(v);
   endfunction

endpackage

### rtl/pose_to_rigid_transform_unit.sv
// Top level: pose to homogeneous transform and rigid inverse, six rows a pose.
// Usage:
//  - req_ channel carries one pose word: position Q16.16, angles Q3.13.
//  - rsp_ channel returns six row words per pose: forward rows 0..2, then
//    inverse rows 0..2; rsp_last_row marks the sixth.
//  - Pipeline: a 30-stage CORDIC (one rotation per stage), then a product
//    stage, a sum/clamp stage, a three-lane translation multiply stage, a
//    translation sum stage, then a row serialiser.
//  - The single result port sets the pace: a new pose enters the serialiser
//    only as the last row of the one before is taken; req_stall is raised
//    whenever a finished pose waits at the last stage because the serialiser
//    still holds rows, whether or not the stages behind it hold poses.
//  - Stall on rsp_: the pipeline holds once a finished pose waits at its
//    last stage; no word is lost or repeated.
//  - Reset clears valid bits and the row counter only; payload registers are left as they are.
module pose_to_rigid_transform_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_inverse_flag,
   output logic [1:0] rsp_row_index,
   output logic signed [15:0] rsp_col_a,
   output logic signed [15:0] rsp_col_b,
   output logic signed [15:0] rsp_col_c,
   output logic signed [31:0] rsp_offset,
   output logic rsp_last_row
);
   localparam int RW = ptrt_pkg::RW;
   localparam int N = ptrt_pkg::CORDIC_STEPS;
   localparam int PW = RW + 32;
   localparam int AW = PW + 2;

   // position travels beside the CORDIC
   logic signed [31:0] pos_ff [N+1][3];

   logic advance;
   logic cordic_valid;
   logic signed [15:0] angles [3];
   ptrt_pkg::rot_type sn [3];
   ptrt_pkg::rot_type cs [3];

   // serialiser
   logic busy_ff;
   logic [2:0] cnt_ff;
   logic signed [15:0] fwd_ff [3][3];
   logic signed [31:0] toff_ff [3];
   logic signed [31:0] ioff_ff [3];

   logic out_free;
   assign out_free = !busy_ff || (!rsp_stall && cnt_ff == 3'd5);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   assign advance = !v4_ff || out_free;
   assign req_stall = !advance;

   assign angles[0] = req_pitch_angle;
   assign angles[1] = req_yaw_angle;
   assign angles[2] = req_roll_angle;

   ptrt_cordic u_cordic (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .angle(angles), .out_valid(cordic_valid), .sin_out(sn), .cos_out(cs)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff[0][0] <= req_pos_x;
         pos_ff[0][1] <= req_pos_y;
         pos_ff[0][2] <= req_pos_z;
         for (int i = 0; i < N; i++) pos_ff[i+1] <= pos_ff[i];
      end
   end

   // stage 1: two-factor products, p and q
   ptrt_pkg::rot_type s1_ff, s2_ff, c2_ff;
   ptrt_pkg::rot_type c1c2_ff, c1s2_ff, c0s2_ff, c0c2_ff, s0c1_ff, s0s2_ff;
   ptrt_pkg::rot_type s0c2_ff, c0c1_ff, p_ff, q_ff;
   logic signed [31:0] t1_ff [3];

   // stage 2: entries
   ptrt_pkg::rot_type r_ff [3][3];
   logic signed [31:0] t2_ff [3];

   // stage 3: translation products, entries rounded to 16 bits
   logic signed [PW-1:0] m_ff [3][3];
   logic signed [31:0] t3_ff [3];
   logic signed [15:0] q14_ff [3][3];

   // stage 4: inverse offsets
   logic signed [31:0] io_ff [3];
   logic signed [31:0] t4_ff [3];
   logic signed [15:0] q4_ff [3][3];

   ptrt_pkg::rot_type r_in [3][3];
   logic signed [31:0] io_in [3];

   always_comb begin
      r_in[0][0] = ptrt_pkg::clamp_one((RW+1)'(c1c2_ff));
      r_in[0][1] = ptrt_pkg::clamp_one(-(RW+1)'(c1s2_ff));
      r_in[0][2] = ptrt_pkg::clamp_one((RW+1)'(s1_ff));
      r_in[1][0] = ptrt_pkg::clamp_one((RW+1)'(c0s2_ff)
                   + (RW+1)'(ptrt_pkg::mulf(p_ff, c2_ff)));
      r_in[1][1] = ptrt_pkg::clamp_one((RW+1)'(c0c2_ff)
                   - (RW+1)'(ptrt_pkg::mulf(p_ff, s2_ff)));
      r_in[1][2] = ptrt_pkg::clamp_one(-(RW+1)'(s0c1_ff));
      r_in[2][0] = ptrt_pkg::clamp_one((RW+1)'(s0s2_ff)
                   - (RW+1)'(ptrt_pkg::mulf(q_ff, c2_ff)));
      r_in[2][1] = ptrt_pkg::clamp_one((RW+1)'(s0c2_ff)
                   + (RW+1)'(ptrt_pkg::mulf(q_ff, s2_ff)));
      r_in[2][2] = ptrt_pkg::clamp_one((RW+1)'(c0c1_ff));
   end

   always_comb begin
      logic signed [AW-1:0] acc;
      logic signed [AW-1:0] sh;
      for (int j = 0; j < 3; j++) begin
         acc = -(AW'(m_ff[0][j]) + AW'(m_ff[1][j]) + AW'(m_ff[2][j]));
         sh = (acc + (AW'(1) <<< (ptrt_pkg::ROT_FRAC_BITS - 1)))
              >>> ptrt_pkg::ROT_FRAC_BITS;
         if (sh > AW'(32'sh7FFFFFFF)) io_in[j] = 32'sh7FFFFFFF;
         else if (sh < -AW'(64'sh80000000)) io_in[j] = 32'sh80000000;
         else io_in[j] = 32'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= cordic_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
      if (advance) begin
         s1_ff <= sn[1]; s2_ff <= sn[2]; c2_ff <= cs[2];
         c1c2_ff <= ptrt_pkg::mulf(cs[1], cs[2]);
         c1s2_ff <= ptrt_pkg::mulf(cs[1], sn[2]);
         c0s2_ff <= ptrt_pkg::mulf(cs[0], sn[2]);
         c0c2_ff <= ptrt_pkg::mulf(cs[0], cs[2]);
         s0c1_ff <= ptrt_pkg::mulf(sn[0], cs[1]);
         s0s2_ff <= ptrt_pkg::mulf(sn[0], sn[2]);
         s0c2_ff <= ptrt_pkg::mulf(sn[0], cs[2]);
         c0c1_ff <= ptrt_pkg::mulf(cs[0], cs[1]);
         p_ff <= ptrt_pkg::mulf(sn[0], sn[1]);
         q_ff <= ptrt_pkg::mulf(cs[0], sn[1]);
         t1_ff <= pos_ff[N];
         r_ff <= r_in;
         t2_ff <= t1_ff;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               m_ff[i][j] <= r_ff[i][j] * t2_ff[i];
               q14_ff[i][j] <= ptrt_pkg::to_q14(r_ff[i][j]);
            end
         t3_ff <= t2_ff;
         io_ff <= io_in;
         t4_ff <= t3_ff;
         q4_ff <= q14_ff;
      end
   end

   // serialiser: load a finished pose, then step through six rows
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff && !rsp_stall && cnt_ff != 3'd5) begin
         cnt_ff <= cnt_ff + 3'd1;
      end else if (out_free) begin
         busy_ff <= v4_ff;
         cnt_ff <= '0;
      end
      if (out_free && v4_ff) begin
         fwd_ff <= q4_ff;
         toff_ff <= t4_ff;
         ioff_ff <= io_ff;
      end
   end

   logic [1:0] row;
   assign row = cnt_ff >= 3'd3 ? 2'(cnt_ff - 3'd3) : cnt_ff[1:0];
   assign rsp_valid = busy_ff;
   assign rsp_inverse_flag = cnt_ff >= 3'd3;
   assign rsp_row_index = row;
   assign rsp_last_row = cnt_ff == 3'd5;
   assign rsp_col_a = rsp_inverse_flag ? fwd_ff[0][row] : fwd_ff[row][0];
   assign rsp_col_b = rsp_inverse_flag ? fwd_ff[1][row] : fwd_ff[row][1];
   assign rsp_col_c = rsp_inverse_flag ? fwd_ff[2][row] : fwd_ff[row][2];
   assign rsp_offset = rsp_inverse_flag ? ioff_ff[row] : toff_ff[row];
endmodule

### rtl/ptrt_cordic.sv
// Pipelined 30-stage CORDIC: three angles in lock step, sine and cosine out.
module ptrt_cordic (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic signed [15:0] angle [3],
   output logic out_valid,
   output ptrt_pkg::rot_type sin_out [3],
   output ptrt_pkg::rot_type cos_out [3]
);
   localparam int N = ptrt_pkg::CORDIC_STEPS;
   localparam int SH = 30 - ptrt_pkg::ROT_FRAC_BITS;
   localparam int CW = ptrt_pkg::CW;

   ptrt_pkg::cordic_type stage_ff [N+1][3];
   ptrt_pkg::cordic_type stage_in [N+1][3];
   logic [N:0] valid_ff;

   always_comb begin
      logic signed [16:0] a;
      for (int k = 0; k < 3; k++) begin
         a = 17'(angle[k]);
         stage_in[0][k].neg = 1'b0;
         if (a > 17'(ptrt_pkg::HALF_PI)) begin
            a = a - ptrt_pkg::PI_Q13;
            stage_in[0][k].neg = 1'b1;
         end else if (a < -17'(ptrt_pkg::HALF_PI)) begin
            a = a + ptrt_pkg::PI_Q13;
            stage_in[0][k].neg = 1'b1;
         end
         stage_in[0][k].x = ptrt_pkg::CORDIC_GAIN;
         stage_in[0][k].y = '0;
         stage_in[0][k].z = ptrt_pkg::ZW'(a) <<< 17;
      end
      for (int i = 0; i < N; i++) begin
         for (int k = 0; k < 3; k++) begin
            stage_in[i+1][k].neg = stage_ff[i][k].neg;
            if (!stage_ff[i][k].z[ptrt_pkg::ZW-1]) begin
               stage_in[i+1][k].x = stage_ff[i][k].x - (stage_ff[i][k].y >>> i);
               stage_in[i+1][k].y = stage_ff[i][k].y + (stage_ff[i][k].x >>> i);
               stage_in[i+1][k].z = stage_ff[i][k].z - ptrt_pkg::atan_entry(5'(i));
            end else begin
               stage_in[i+1][k].x = stage_ff[i][k].x + (stage_ff[i][k].y >>> i);
               stage_in[i+1][k].y = stage_ff[i][k].y - (stage_ff[i][k].x >>> i);
               stage_in[i+1][k].z = stage_ff[i][k].z + ptrt_pkg::atan_entry(5'(i));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
      if (advance) begin
         for (int i = 0; i <= N; i++)
            for (int k = 0; k < 3; k++)
               stage_ff[i][k] <= stage_in[i][k];
      end
   end

   assign out_valid = valid_ff[N];

   always_comb begin
      logic signed [CW-1:0] rx, ry;
      for (int k = 0; k < 3; k++) begin
         rx = (stage_ff[N][k].x + (CW'(1) <<< (SH - 1))) >>> SH;
         ry = (stage_ff[N][k].y + (CW'(1) <<< (SH - 1))) >>> SH;
         cos_out[k] = stage_ff[N][k].neg ? -ptrt_pkg::RW'(rx) : ptrt_pkg::RW'(rx);
         sin_out[k] = stage_ff[N][k].neg ? -ptrt_pkg::RW'(ry) : ptrt_pkg::RW'(ry);
      end
   end
endmodule
